// File: rtl/wtg_pkg.sv
// ----------------------------------------------------------------------------
// wtg_pkg
// types, constants and wavetable helpers shared by the tone generator modules
// ----------------------------------------------------------------------------
package wtg_pkg;

    localparam int PERIOD_W    = 20;
    localparam int HOLD_W      = 16;
    localparam int ELAPSED_W   = 27;
    localparam int LEN_W       = 26;
    localparam int FREQ_W      = 12;
    localparam int DUR_W       = 16;
    localparam int DAC_W       = 12;
    localparam int IDX_W       = 4;
    localparam int SINE_W      = 17;
    localparam int PROD_W      = SINE_W + DAC_W;
    localparam int DIV_STEPS   = PERIOD_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    localparam logic [PERIOD_W-1:0] US_PER_SEC       = 20'd1000000;
    localparam logic [PERIOD_W-1:0] LOOP_OVERHEAD_US = 20'd1322;
    localparam logic [FREQ_W-1:0]   MAX_FREQUENCY_HZ = 12'd741;
    localparam logic [LEN_W-1:0]    US_PER_MS        = 26'd1000;
    localparam logic [DAC_W-1:0]    VOL_MIN          = 12'd10;
    localparam logic [DAC_W-1:0]    VOL_RESET        = 12'd4095;
    localparam logic [IDX_W-1:0]    TRI_PEAK_IDX     = 4'd8;
    localparam logic [IDX_W-1:0]    SQ_HALF_IDX      = 4'd8;

    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_TRIANGLE = 2'd1,
        WAVE_SAWTOOTH = 2'd2,
        WAVE_SQUARE   = 2'd3
    } t_wave;

    typedef struct packed {
        logic tick;
        logic start_latch;
        logic div_step;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic freq_ok;
    } t_status;

    // sine table offset by full scale: 32768 + round(32768*sin(2*pi*k/16))
    function automatic logic [SINE_W-1:0] sine_offset(input logic [IDX_W-1:0] k);
        logic [SINE_W-1:0] s;
        case (k)
            4'd0:    s = 17'd32768;
            4'd1:    s = 17'd45308;
            4'd2:    s = 17'd55938;
            4'd3:    s = 17'd63042;
            4'd4:    s = 17'd65536;
            4'd5:    s = 17'd63042;
            4'd6:    s = 17'd55938;
            4'd7:    s = 17'd45308;
            4'd8:    s = 17'd32768;
            4'd9:    s = 17'd20228;
            4'd10:   s = 17'd9598;
            4'd11:   s = 17'd2494;
            4'd12:   s = 17'd0;
            4'd13:   s = 17'd2494;
            4'd14:   s = 17'd9598;
            4'd15:   s = 17'd20228;
            default: s = 17'd32768;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/wavetable_tone_generator.sv
// ----------------------------------------------------------------------------
// wavetable_tone_generator
// 16-step wavetable tone generator for a 12-bit dac, microsecond tick driven
// ----------------------------------------------------------------------------
// timing: a tick or an ignored start gives its result in the cycle after acceptance
// a valid start runs the 20-step period divider, then waits for a free output slot
// throughput: one tick per cycle unless the output stalls; a valid start stalls the input until done
// reset: synchronous active low, note state cleared, block idle, max_volume 4095
module wavetable_tone_generator (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [wtg_pkg::DAC_W-1:0]   i_cfg_wr_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_operation,
    input  logic [wtg_pkg::FREQ_W-1:0]  i_frequency_hz,
    input  logic [1:0]                  i_waveform,
    input  logic [wtg_pkg::DUR_W-1:0]   i_duration_ms,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [wtg_pkg::DAC_W-1:0]   o_dac_value,
    output logic                        o_playing
);

    wtg_pkg::t_cmd    cmd;
    wtg_pkg::t_status status;

    wtg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    wtg_datapath u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_frequency_hz (i_frequency_hz),
        .i_waveform     (i_waveform),
        .i_duration_ms  (i_duration_ms),
        .i_cmd          (cmd),
        .o_status       (status),
        .o_dac_value    (o_dac_value),
        .o_playing      (o_playing)
    );

endmodule

// File: rtl/wtg_ctrl.sv
// ----------------------------------------------------------------------------
// wtg_ctrl
// handshake and sequencing control: ticks and invalid starts load the output directly, valid starts run the divider
// ----------------------------------------------------------------------------
module wtg_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_operation,
    input  logic             i_out_stall,
    input  wtg_pkg::t_status i_status,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output wtg_pkg::t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_FIN  = 3'b100
    } t_state;

    t_state                          r_state, n_state;
    logic [wtg_pkg::DIV_CNT_W-1:0]   r_cnt, n_cnt;
    logic                            r_out_valid, n_out_valid;
    logic                            slot_free;
    logic                            in_ready;
    logic                            accept;

    assign slot_free   = !r_out_valid || !i_out_stall;
    assign in_ready    = (r_state == S_IDLE) && slot_free;
    assign accept      = i_in_valid && in_ready;
    assign o_in_stall  = !in_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_operation == wtg_pkg::OP_TICK) begin
                        o_cmd.tick     = 1'b1;
                        o_cmd.load_out = 1'b1;
                    end else if (i_status.freq_ok) begin
                        o_cmd.start_latch = 1'b1;
                        n_cnt             = '0;
                        n_state           = S_DIV;
                    end else begin
                        o_cmd.load_out = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt + 1'b1;
                if (r_cnt == wtg_pkg::DIV_CNT_W'(wtg_pkg::DIV_STEPS - 1)) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (slot_free) begin
                    o_cmd.commit   = 1'b1;
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        n_out_valid = (r_out_valid && i_out_stall) || o_cmd.load_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: rtl/wtg_datapath.sv
// ----------------------------------------------------------------------------
// wtg_datapath
// note state, period divider, wavetable sample unit and output register
// ----------------------------------------------------------------------------
module wtg_datapath (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_wr_en,
    input  logic [wtg_pkg::DAC_W-1:0]          i_cfg_wr_data,
    input  logic [wtg_pkg::FREQ_W-1:0]         i_frequency_hz,
    input  logic [1:0]                         i_waveform,
    input  logic [wtg_pkg::DUR_W-1:0]          i_duration_ms,
    input  wtg_pkg::t_cmd                      i_cmd,
    output wtg_pkg::t_status                   o_status,
    output logic [wtg_pkg::DAC_W-1:0]          o_dac_value,
    output logic                               o_playing
);

    logic [wtg_pkg::DAC_W-1:0]      r_max_vol;
    logic [wtg_pkg::PERIOD_W-1:0]   r_period;
    logic [wtg_pkg::HOLD_W-1:0]     r_step_hold;
    logic [wtg_pkg::HOLD_W-1:0]     r_hold_cnt;
    logic [wtg_pkg::IDX_W-1:0]      r_idx;
    logic [wtg_pkg::ELAPSED_W-1:0]  r_elapsed;
    logic [wtg_pkg::LEN_W-1:0]      r_note_len;
    logic [1:0]                     r_wave;
    logic                           r_active;
    logic [wtg_pkg::DAC_W-1:0]      r_held;

    logic [wtg_pkg::FREQ_W-1:0]     r_div_den;
    logic [wtg_pkg::FREQ_W-1:0]     r_div_rem;
    logic [wtg_pkg::PERIOD_W-1:0]   r_div_quo;
    logic [wtg_pkg::LEN_W-1:0]      r_pend_len;
    logic [1:0]                     r_pend_wave;

    logic [wtg_pkg::DAC_W-1:0]      r_out_dac;
    logic                           r_out_playing;

    logic [wtg_pkg::FREQ_W:0]       rem_sh;
    logic [wtg_pkg::FREQ_W:0]       rem_sub;
    logic                           rem_ge;

    logic [wtg_pkg::SINE_W-1:0]     mul_a;
    logic [wtg_pkg::DAC_W-1:0]      mul_b;
    logic [wtg_pkg::PROD_W-1:0]     prod;
    logic [wtg_pkg::DAC_W-1:0]      sample;

    logic [wtg_pkg::HOLD_W-1:0]     hold_eff;
    logic [wtg_pkg::HOLD_W-1:0]     hold_inc;
    logic [wtg_pkg::IDX_W-1:0]      idx_inc;
    logic [wtg_pkg::ELAPSED_W-1:0]  elapsed_sum;
    logic [wtg_pkg::HOLD_W-1:0]     new_step_hold;
    logic [wtg_pkg::PERIOD_W-1:0]   period_excess;
    logic [wtg_pkg::DAC_W-1:0]      vol_sat;

    assign o_status.freq_ok = (i_frequency_hz != '0)
                           && (i_frequency_hz <= wtg_pkg::MAX_FREQUENCY_HZ);

    // restoring division step
    assign rem_sh  = {r_div_rem, r_div_quo[wtg_pkg::PERIOD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_div_den};
    assign rem_sub = rem_sh - {1'b0, r_div_den};

    // wavetable sample
    always_comb begin
        mul_a = '0;
        mul_b = r_max_vol;
        case (wtg_pkg::t_wave'(r_wave))
            wtg_pkg::WAVE_SINE: begin
                mul_a = wtg_pkg::sine_offset(r_idx);
                mul_b = {1'b0, r_max_vol[wtg_pkg::DAC_W-1:1]};
            end
            wtg_pkg::WAVE_TRIANGLE: begin
                if (r_idx <= wtg_pkg::TRI_PEAK_IDX) begin
                    mul_a = wtg_pkg::SINE_W'(r_idx);
                end else begin
                    mul_a = wtg_pkg::SINE_W'(5'd16 - {1'b0, r_idx});
                end
            end
            wtg_pkg::WAVE_SAWTOOTH: begin
                mul_a = wtg_pkg::SINE_W'(r_idx);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod = wtg_pkg::PROD_W'(mul_a) * wtg_pkg::PROD_W'(mul_b);

    always_comb begin
        case (wtg_pkg::t_wave'(r_wave))
            wtg_pkg::WAVE_SINE:     sample = prod[15 +: wtg_pkg::DAC_W];
            wtg_pkg::WAVE_TRIANGLE: sample = prod[3 +: wtg_pkg::DAC_W];
            wtg_pkg::WAVE_SAWTOOTH: sample = prod[4 +: wtg_pkg::DAC_W];
            default: begin
                sample = (r_idx < wtg_pkg::SQ_HALF_IDX) ? r_max_vol : '0;
            end
        endcase
    end

    assign hold_eff    = (r_step_hold == '0) ? wtg_pkg::HOLD_W'(1) : r_step_hold;
    assign hold_inc    = r_hold_cnt + 1'b1;
    assign idx_inc     = r_idx + 1'b1;
    assign elapsed_sum = r_elapsed + wtg_pkg::ELAPSED_W'(r_period);

    assign period_excess = r_div_quo - wtg_pkg::LOOP_OVERHEAD_US;
    assign new_step_hold = (r_div_quo >= wtg_pkg::LOOP_OVERHEAD_US)
                         ? wtg_pkg::HOLD_W'(period_excess >> 4) : '0;

    assign vol_sat = (i_cfg_wr_data < wtg_pkg::VOL_MIN) ? wtg_pkg::VOL_MIN : i_cfg_wr_data;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_vol   <= wtg_pkg::VOL_RESET;
            r_period    <= '0;
            r_step_hold <= '0;
            r_hold_cnt  <= '0;
            r_idx       <= '0;
            r_elapsed   <= '0;
            r_note_len  <= '0;
            r_wave      <= '0;
            r_active    <= 1'b0;
            r_held      <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_max_vol <= vol_sat;
            end
            if (i_cmd.commit) begin
                r_period    <= r_div_quo;
                r_step_hold <= new_step_hold;
                r_hold_cnt  <= '0;
                r_idx       <= '0;
                r_elapsed   <= '0;
                r_note_len  <= r_pend_len;
                r_wave      <= r_pend_wave;
                r_active    <= (r_pend_len != '0);
            end else if (i_cmd.tick && r_active) begin
                r_held <= sample;
                if (hold_inc >= hold_eff) begin
                    r_hold_cnt <= '0;
                    r_idx      <= idx_inc;
                    if (idx_inc == '0) begin
                        r_elapsed <= elapsed_sum;
                        if (elapsed_sum >= wtg_pkg::ELAPSED_W'(r_note_len)) begin
                            r_active <= 1'b0;
                        end
                    end
                end else begin
                    r_hold_cnt <= hold_inc;
                end
            end
        end
    end

    // divider and pending start payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_latch) begin
            r_div_den   <= i_frequency_hz;
            r_div_rem   <= '0;
            r_div_quo   <= wtg_pkg::US_PER_SEC;
            r_pend_len  <= wtg_pkg::LEN_W'(i_duration_ms) * wtg_pkg::US_PER_MS;
            r_pend_wave <= i_waveform;
        end else if (i_cmd.div_step) begin
            r_div_rem <= rem_ge ? rem_sub[wtg_pkg::FREQ_W-1:0]
                                : rem_sh[wtg_pkg::FREQ_W-1:0];
            r_div_quo <= {r_div_quo[wtg_pkg::PERIOD_W-2:0], rem_ge};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            if (i_cmd.tick && r_active) begin
                r_out_dac <= sample;
            end else begin
                r_out_dac <= r_held;
            end
            if (i_cmd.commit) begin
                r_out_playing <= (r_pend_len != '0);
            end else begin
                r_out_playing <= r_active;
            end
        end
    end

    assign o_dac_value = r_out_dac;
    assign o_playing   = r_out_playing;

endmodule
